>>> hdl/card_reader_column_queue_unit_defines.svh
// Assertion macros for the card reader column queue.
// Used by crcq_dp; expects clk and rst_n in scope at the point of use.
`ifndef CARD_READER_COLUMN_QUEUE_UNIT_DEFINES_SVH
`define CARD_READER_COLUMN_QUEUE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CRCQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold at every edge out of reset
`define CRCQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> hdl/crcq_pkg.sv
// Shared types, constants and the column-code to ASCII conversion.
// No dependencies.
`default_nettype none
package crcq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int HW_W        = 9;
  localparam int CODE_W      = 8;
  localparam int CHAR_W      = 7;
  localparam int RES_W       = 3;

  localparam logic [HW_W-1:0]   HW_RESET = 9'd160;
  localparam logic [CODE_W-1:0] EOL_CODE = 8'o140;
  localparam logic [CHAR_W-1:0] ASCII_NL = 7'h0A;
  localparam logic [CHAR_W-1:0] ASCII_SP = 7'h20;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_EVENT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_CLOSED  = 2'd0,
    MODE_WAITING = 2'd1,
    MODE_READING = 2'd2,
    MODE_EOF     = 2'd3
  } mode_t;

  localparam logic [RES_W-1:0] RES_OK       = 3'd0;
  localparam logic [RES_W-1:0] RES_REFUSED  = 3'd1;
  localparam logic [RES_W-1:0] RES_NO_DATA  = 3'd2;
  localparam logic [RES_W-1:0] RES_EOF      = 3'd3;
  localparam logic [RES_W-1:0] RES_OVERFLOW = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_CONV = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request fields
    logic exec;   // perform the operation
    logic conv;   // convert popped code
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop;    // current request pops a code
  } sts_t;

  localparam int FOLD_N = 72;
  localparam logic [CHAR_W-1:0] FOLD_TABLE [FOLD_N] = '{
    7'h20, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h20, 7'h3A, 7'h23, 7'h40, 7'h60, 7'h3D, 7'h22,
    7'h39, 7'h30, 7'h2F, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77,
    7'h78, 7'h79, 7'h20, 7'h5D, 7'h2C, 7'h25, 7'h5F, 7'h3E,
    7'h3F, 7'h7A, 7'h2D, 7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E,
    7'h6F, 7'h70, 7'h71, 7'h20, 7'h21, 7'h24, 7'h2A, 7'h29,
    7'h3B, 7'h5C, 7'h72, 7'h26, 7'h61, 7'h62, 7'h63, 7'h64,
    7'h65, 7'h66, 7'h67, 7'h68, 7'h20, 7'h5B, 7'h2E, 7'h3C,
    7'h28, 7'h2B, 7'h5E, 7'h69, 7'h20, 7'h20, 7'h20, 7'h20
  };

  // fold: drop 040 at or above 0200, then remove 017 per 040 group
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] v;
    logic [2:0]        grp;
    logic [CODE_W-1:0] sub;
    logic [CHAR_W-1:0] ch;
    v = code;
    if (v >= 8'o200) begin
      v = v - 8'o040;
    end
    grp = v[7:5];
    sub = {1'b0, grp, 4'b0000} - {5'b00000, grp};
    v   = v - sub;
    if (code == EOL_CODE) begin
      ch = ASCII_NL;
    end else if (v > 8'o107) begin
      ch = ASCII_SP;
    end else begin
      ch = FOLD_TABLE[v[6:0]];
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> hdl/crcq_ctrl.sv
// Sequencer for the card reader queue: one request at a time.
// Depends on crcq_pkg.
`default_nettype none
module crcq_ctrl
  import crcq_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = sts.pop ? ST_CONV : ST_OUT;
      ST_CONV: state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_CONV: cmd.conv = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/crcq_dp.sv
// Datapath: reader mode, code FIFO memory with pointers and count, result registers.
// Depends on crcq_pkg and card_reader_column_queue_unit_defines.svh.
`default_nettype none
`include "card_reader_column_queue_unit_defines.svh"
module crcq_dp
  import crcq_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  wire  [HW_W-1:0]   high_water,
  input  wire  [1:0]        in_opcode,
  input  wire               in_write_flag,
  input  wire               in_status_error,
  input  wire               in_status_card_done,
  input  wire  [CODE_W-1:0] in_column_code,
  output logic [RES_W-1:0]  result_code,
  output logic              char_valid,
  output logic [CHAR_W-1:0] ascii_char,
  output logic              start_reader,
  output logic [1:0]        reader_state,
  output logic [CNT_W-1:0]  queued_count
);

  // captured request
  op_t               op_r;
  logic              wflag_r, err_r, done_r;
  logic [CODE_W-1:0] col_r;

  // queue state
  mode_t             mode_r, mode_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  fill_count_r, fill_count_nxt;
  logic [CODE_W-1:0] mem [QUEUE_DEPTH];
  logic [CODE_W-1:0] rd_data_r;

  // result
  logic [RES_W-1:0]  res_r, res_nxt;
  logic              valid_r, start_r, start_nxt;
  logic [CHAR_W-1:0] ascii_r;

  logic              push_en, pop_en, full, below_hw, eff_read;
  logic [CODE_W-1:0] push_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_opcode);
      wflag_r <= in_write_flag;
      err_r   <= in_status_error;
      done_r  <= in_status_card_done;
      col_r   <= in_column_code;
    end
  end

  assign full     = (fill_count_r == CNT_W'(QUEUE_DEPTH));
  assign below_hw = (32'(fill_count_r) < 32'(high_water));
  // waiting without error moves to reading and is handled there
  assign eff_read = (mode_r == MODE_READING) || (mode_r == MODE_WAITING && !err_r);

  always_comb begin
    mode_nxt       = mode_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_count_nxt = fill_count_r;
    res_nxt        = RES_OK;
    start_nxt      = 1'b0;
    push_en        = 1'b0;
    push_data      = col_r;
    pop_en         = 1'b0;
    unique case (op_r)
      OP_OPEN: begin
        if (wflag_r || mode_r != MODE_CLOSED) begin
          res_nxt = RES_REFUSED;
        end else begin
          mode_nxt  = MODE_WAITING;
          start_nxt = 1'b1;
        end
      end
      OP_EVENT: begin
        if (mode_r == MODE_WAITING && err_r) begin
          start_nxt = 1'b1;
        end else if (eff_read) begin
          push_en = 1'b1;
          if (err_r) begin
            mode_nxt  = MODE_EOF;
            push_data = EOL_CODE;
          end else if (done_r) begin
            mode_nxt  = MODE_WAITING;
            start_nxt = below_hw;
            push_data = EOL_CODE;
          end else begin
            mode_nxt  = MODE_READING;
          end
        end
      end
      OP_READ: begin
        if (fill_count_r == '0) begin
          if (mode_r == MODE_EOF) begin
            res_nxt = RES_EOF;
          end else begin
            res_nxt   = RES_NO_DATA;
            start_nxt = done_r && below_hw;
          end
        end else begin
          pop_en         = 1'b1;
          head_nxt       = head_r + 1'b1;
          fill_count_nxt = fill_count_r - 1'b1;
        end
      end
      OP_CLOSE: begin
        head_nxt       = '0;
        tail_nxt       = '0;
        fill_count_nxt = '0;
        mode_nxt       = MODE_CLOSED;
      end
      default: ;
    endcase
    if (push_en) begin
      if (full) begin
        push_en = 1'b0;
        res_nxt = RES_OVERFLOW;
      end else begin
        tail_nxt       = tail_r + 1'b1;
        fill_count_nxt = fill_count_r + 1'b1;
      end
    end
  end

  assign sts.pop = pop_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_CLOSED;
      head_r       <= '0;
      tail_r       <= '0;
      fill_count_r <= '0;
    end else if (cmd.exec) begin
      mode_r       <= mode_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_count_r <= fill_count_nxt;
    end
  end

  // FIFO storage: one write or one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.exec && push_en) begin
      mem[tail_r] <= push_data;
    end
    if (cmd.exec && pop_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r   <= res_nxt;
      start_r <= start_nxt;
      valid_r <= pop_en;
      ascii_r <= '0;
    end else if (cmd.conv) begin
      ascii_r <= to_ascii(rd_data_r);
    end
  end

  assign result_code  = res_r;
  assign char_valid   = valid_r;
  assign ascii_char   = ascii_r;
  assign start_reader = start_r;
  assign reader_state = mode_r;
  assign queued_count = fill_count_r;

  `CRCQ_ASSERT_ALWAYS(a_count_bound, fill_count_r <= CNT_W'(QUEUE_DEPTH), "fill count over depth")
  `CRCQ_ASSERT_ALWAYS(a_count_ptrs, fill_count_r[ADDR_W-1:0] == ADDR_W'(tail_r - head_r), "count disagrees with pointers")
  `CRCQ_ASSERT_IMPL(a_count_on_exec, fill_count_r != $past(fill_count_r), $past(cmd.exec), "count moved outside exec")
  `CRCQ_ASSERT_IMPL(a_mode_on_exec, mode_r != $past(mode_r), $past(cmd.exec), "mode moved outside exec")

endmodule
`default_nettype wire

>>> hdl/card_reader_column_queue_unit.sv
// Card reader column queue: top level with stream channels and APB register port.
// Depends on crcq_pkg, crcq_ctrl and crcq_dp.
//
// Usage:
//   in_*  : one request per transfer. in_tuser carries the opcode (open,
//           column event, read one character, close); in_tdata the flags and
//           the column code.
//   out_* : exactly one result per request, in request order.
//   cfg_* : APB port, one register (high_water, byte address 0), reset 160.
//           Writes are expected only while no request is in flight.
// Timing: a request is accepted only when the block is idle. Its result is
//   valid once the EXEC state has run, or once EXEC and CONV have run for a
//   read that pops a code (the FIFO memory read is registered, then the code
//   is folded and looked up). The next request is taken the cycle after the
//   result is accepted.
// Stall: while out_tready is low the result holds and in_tready stays low.
// Reset (rst_n low, synchronous): reader closed, queue empty, high_water 160.
//   The code store is not cleared; only written entries are ever read.
`default_nettype none
module card_reader_column_queue_unit
  import crcq_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // request stream
  input  wire         in_tvalid,
  output logic        in_tready,
  // [0] write_flag, [1] status_error, [2] status_card_done, [10:3] column_code
  input  wire  [15:0] in_tdata,
  // [1:0] opcode
  input  wire  [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  // [2:0] result_code, [3] char_valid, [10:4] ascii_char, [11] start_reader,
  // [13:12] reader_state, [22:14] queued_count
  output logic [23:0] out_tdata,
  // register port
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic ADDR_HIGH_WATER = 1'b0;

  cmd_t cmd;
  sts_t sts;

  logic [HW_W-1:0]   high_water_r;
  logic [RES_W-1:0]  result_code;
  logic              char_valid;
  logic [CHAR_W-1:0] ascii_char;
  logic              start_reader;
  logic [1:0]        reader_state;
  logic [CNT_W-1:0]  queued_count;

  // register file: write on the access phase, register index in paddr[2]
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_water_r <= HW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == ADDR_HIGH_WATER) begin
      high_water_r <= cfg_pwdata[HW_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ADDR_HIGH_WATER) begin
      cfg_prdata = 32'(high_water_r);
    end
  end

  crcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crcq_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .high_water          (high_water_r),
    .in_opcode           (in_tuser),
    .in_write_flag       (in_tdata[0]),
    .in_status_error     (in_tdata[1]),
    .in_status_card_done (in_tdata[2]),
    .in_column_code      (in_tdata[10:3]),
    .result_code         (result_code),
    .char_valid          (char_valid),
    .ascii_char          (ascii_char),
    .start_reader        (start_reader),
    .reader_state        (reader_state),
    .queued_count        (queued_count)
  );

  assign out_tdata = {1'b0, queued_count, reader_state, start_reader,
                      ascii_char, char_valid, result_code};

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for card_reader_column_queue_unit: a directed table followed by
// random request phases, with every result checked against an in-bench reader/FIFO model.
// Depends on crcq_pkg and the card_reader_column_queue_unit RTL only.
module tb
  import crcq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // result fields, most significant first, so the struct overlays out_tdata[22:0]
  typedef struct packed {
    logic [8:0]       cnt;
    mode_t            md;
    logic             st;
    logic [CHAR_W-1:0] ch;
    logic             cv;
    logic [RES_W-1:0] res;
  } outcome_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    op_t        op;
    logic       w;
    logic       e;
    logic       d;
    logic [7:0] col;
    logic       typed;
    outcome_t   want;
  } row_t;

  localparam logic [2:0] ADDR_HIGH_WATER = 3'd0;
  localparam int         QUIET_LIMIT     = 4000;  // cycles with no transfer at all
  localparam int         PHASE_ITEMS     = 250;
  localparam int         NUM_PHASES      = 6;

  localparam outcome_t NO_WANT = '{9'd0, MODE_CLOSED, 1'b0, 7'h00, 1'b0, RES_OK};

  // want = '{count, mode, start, char, char_valid, result}
  localparam row_t DIRECTED [0:25] = '{
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_CLOSED,  1'b0, 7'h00, 1'b0, RES_NO_DATA}},   // read right after reset
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, 8'hA5, 1'b1,
      '{9'd0, MODE_CLOSED,  1'b0, 7'h00, 1'b0, RES_OK}},        // event while closed
    '{OP_OPEN,  1'b1, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_CLOSED,  1'b0, 7'h00, 1'b0, RES_REFUSED}},   // open for writing
    '{OP_OPEN,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_WAITING, 1'b1, 7'h00, 1'b0, RES_OK}},
    '{OP_OPEN,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_WAITING, 1'b0, 7'h00, 1'b0, RES_REFUSED}},   // already open
    '{OP_EVENT, 1'b0, 1'b1, 1'b0, 8'h3C, 1'b1,
      '{9'd0, MODE_WAITING, 1'b1, 7'h00, 1'b0, RES_OK}},        // error while waiting
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd1, MODE_READING, 1'b0, 7'h00, 1'b0, RES_OK}},        // waiting -> reading
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b1,
      '{9'd2, MODE_READING, 1'b0, 7'h00, 1'b0, RES_OK}},
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, EOL_CODE, 1'b1,
      '{9'd3, MODE_READING, 1'b0, 7'h00, 1'b0, RES_OK}},
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, 8'o200, 1'b1,
      '{9'd4, MODE_READING, 1'b0, 7'h00, 1'b0, RES_OK}},
    '{OP_EVENT, 1'b0, 1'b0, 1'b1, 8'h55, 1'b1,
      '{9'd5, MODE_WAITING, 1'b1, 7'h00, 1'b0, RES_OK}},        // card end, marker
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd4, MODE_WAITING, 1'b0, ASCII_SP, 1'b1, RES_OK}},     // code 0 -> space
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd3, MODE_WAITING, 1'b0, ASCII_SP, 1'b1, RES_OK}},     // past the table
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd2, MODE_WAITING, 1'b0, ASCII_NL, 1'b1, RES_OK}},     // raw EOL code
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_WANT},
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_WAITING, 1'b0, ASCII_NL, 1'b1, RES_OK}},     // end-of-line marker
    '{OP_READ,  1'b0, 1'b0, 1'b1, 8'h00, 1'b1,
      '{9'd0, MODE_WAITING, 1'b1, 7'h00, 1'b0, RES_NO_DATA}},   // empty, card done
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_WAITING, 1'b0, 7'h00, 1'b0, RES_NO_DATA}},
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, 8'h41, 1'b0, NO_WANT},
    '{OP_EVENT, 1'b0, 1'b1, 1'b1, 8'h7F, 1'b1,
      '{9'd2, MODE_EOF,     1'b0, 7'h00, 1'b0, RES_OK}},        // error while reading
    '{OP_EVENT, 1'b0, 1'b0, 1'b0, 8'h12, 1'b1,
      '{9'd2, MODE_EOF,     1'b0, 7'h00, 1'b0, RES_OK}},        // ignored at EOF
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_WANT},
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_WANT},
    '{OP_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_EOF,     1'b0, 7'h00, 1'b0, RES_EOF}},       // empty at EOF
    '{OP_OPEN,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
      '{9'd0, MODE_EOF,     1'b0, 7'h00, 1'b0, RES_REFUSED}},
    '{OP_CLOSE, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1,
      '{9'd0, MODE_CLOSED,  1'b0, 7'h00, 1'b0, RES_OK}}
  };

  // per-phase request mix (percent) and high-water setting
  localparam int EVENT_PCT [NUM_PHASES] = '{60, 95, 40, 50, 90, 55};
  localparam int READ_PCT  [NUM_PHASES] = '{35,  3, 55, 45,  8, 40};
  localparam int ERROR_PCT [NUM_PHASES] = '{ 3,  0,  3,  2,  0,  4};
  localparam int WATER_SET [NUM_PHASES] = '{160, 256, 0, 1, 255, -1};  // -1: random

  // column code folding table, 72 entries
  string fold_chars =
    " 12345678 :#@`=\"90/stuvwxy ],%_>?z-jklmnopq !$*);\\r&abcdefgh [.<(+^i    ";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [0] write_flag, [1] status_error, [2] status_card_done,
                                // [10:3] column_code
  logic [1:0]  in_tuser = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [2:0] result_code, [3] char_valid, [10:4] ascii_char,
                                // [11] start_reader, [13:12] reader_state, [22:14] queued_count
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  card_reader_column_queue_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Reader model: mode, column FIFO and high-water mark
  // ---------------------------------------------------------------------------
  mode_t      rd_mode    = MODE_CLOSED;
  logic [7:0] col_fifo [QUEUE_DEPTH];
  logic [7:0] fifo_head  = '0;
  logic [7:0] fifo_tail  = '0;
  int         fifo_fill  = 0;
  int         water_mark = HW_RESET;

  outcome_t   expected_results [$];
  int         fault_count = 0;
  int         quiet_cycles = 0;
  bit         steady = 1'b0;       // no idling on either side while set

  // typed expectation for the request being driven, if any
  bit         typed_on = 1'b0;
  outcome_t   typed_want;

  function automatic bit fifo_push(logic [7:0] code);
    if (fifo_fill >= QUEUE_DEPTH) return 1'b0;   // full: code dropped
    col_fifo[fifo_tail] = code;
    fifo_tail++;
    fifo_fill++;
    return 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] column_to_char(logic [7:0] code);
    int v;
    if (code == EOL_CODE) return ASCII_NL;
    v = code;
    if (v >= 'o200) v -= 'o40;
    v -= 'o17 * (v / 'o40);
    if (v > 'o107) return ASCII_SP;
    return CHAR_W'(fold_chars[v]);
  endfunction

  // Apply one request to the model and return the result it must produce.
  function automatic outcome_t predict_reader_result(op_t op, logic w, logic e, logic d,
                                                     logic [7:0] col);
    outcome_t o;
    bit       handled;
    bit       marker;
    o = NO_WANT;
    case (op)
      OP_OPEN: begin
        if (w || rd_mode != MODE_CLOSED) begin
          o.res = RES_REFUSED;
        end else begin
          rd_mode = MODE_WAITING;
          o.st = 1'b1;
        end
      end
      OP_EVENT: begin
        handled = 1'b0;
        if (rd_mode == MODE_WAITING) begin
          if (e) begin
            o.st = 1'b1;         // restart, stay waiting
            handled = 1'b1;
          end else begin
            rd_mode = MODE_READING;
          end
        end
        if (!handled && rd_mode == MODE_READING) begin
          marker = 1'b1;
          if (e) begin
            rd_mode = MODE_EOF;
          end else if (!d) begin
            if (!fifo_push(col)) o.res = RES_OVERFLOW;
            marker = 1'b0;
          end else begin
            rd_mode = MODE_WAITING;
            if (fifo_fill < water_mark) o.st = 1'b1;  // count before the marker
          end
          if (marker && !fifo_push(EOL_CODE)) o.res = RES_OVERFLOW;
        end
      end
      OP_READ: begin
        if (fifo_fill == 0) begin
          if (rd_mode == MODE_EOF) begin
            o.res = RES_EOF;
          end else begin
            o.res = RES_NO_DATA;
            if (d && fifo_fill < water_mark) o.st = 1'b1;
          end
        end else begin
          o.ch = column_to_char(col_fifo[fifo_head]);
          o.cv = 1'b1;
          fifo_head++;
          fifo_fill--;
        end
      end
      default: begin            // close flushes everything
        fifo_head = '0;
        fifo_tail = '0;
        fifo_fill = 0;
        rd_mode = MODE_CLOSED;
      end
    endcase
    o.md  = rd_mode;
    o.cnt = fifo_fill[8:0];
    return o;
  endfunction

  function automatic void note_fault(string what, int unsigned want, int unsigned got);
    fault_count++;
    if (fault_count <= 10)
      $display("ERROR %s: expected 'h%0h, got 'h%0h", what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both streams at the rising edge. Results are checked
  // against the oldest pending expectation; accepted requests feed the model.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    outcome_t seen;
    outcome_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          note_fault("result with no request pending", 0, out_tdata);
        end else begin
          want = expected_results.pop_front();
          seen = outcome_t'(out_tdata[22:0]);
          if (seen.res !== want.res) note_fault("result_code", want.res, seen.res);
          if (seen.cv  !== want.cv)  note_fault("char_valid", want.cv, seen.cv);
          if (seen.ch  !== want.ch)  note_fault("ascii_char", want.ch, seen.ch);
          if (seen.st  !== want.st)  note_fault("start_reader", want.st, seen.st);
          if (seen.md  !== want.md)  note_fault("reader_state", want.md, seen.md);
          if (seen.cnt !== want.cnt) note_fault("queued_count", want.cnt, seen.cnt);
          if (out_tdata[23] !== 1'b0) note_fault("tdata padding", 0, out_tdata[23]);
        end
      end
      if (in_tvalid && in_tready) begin
        quiet_cycles = 0;
        want = predict_reader_result(op_t'(in_tuser), in_tdata[0], in_tdata[1],
                                     in_tdata[2], in_tdata[10:3]);
        // directed rows carry a hand-typed answer; the model still tracks state
        expected_results.push_back(typed_on ? typed_want : want);
      end
      if (cfg_psel && cfg_penable && cfg_pready) quiet_cycles = 0;
    end
  end

  // watchdog: nothing moving on any port for too long
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("card_reader_column_queue_unit: mismatch");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 18);
  end

  // ---------------------------------------------------------------------------
  // Request driver: changes at the falling edge, waits for the handshake
  // ---------------------------------------------------------------------------
  task automatic send_request(op_t op, logic w, logic e, logic d, logic [7:0] col,
                              bit typed, outcome_t want);
    while (!steady && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_on   = typed;
    typed_want = want;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, col, d, e, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Register write then read-back, only with nothing in flight.
  task automatic set_high_water(logic [8:0] val);
    wait_drained();
    in_tvalid <= 1'b0;
    repeat (6) @(negedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= ADDR_HIGH_WATER;
    cfg_pwdata <= {23'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    water_mark = val;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;         // back to setup, now a read
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {23'd0, val}) note_fault("high_water read-back", val, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int  sent;
    int  r;
    int  ev_cut;
    int  rd_cut;
    op_t op;
    logic w, e, d;
    logic [7:0] col;
    logic [8:0] hw;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, reset value of high_water
    foreach (DIRECTED[i])
      send_request(DIRECTED[i].op, DIRECTED[i].w, DIRECTED[i].e, DIRECTED[i].d,
                   DIRECTED[i].col, DIRECTED[i].typed, DIRECTED[i].want);

    // random phases; each starts with a new high-water mark
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      hw = (WATER_SET[ph] < 0) ? 9'($urandom_range(254, 2)) : 9'(WATER_SET[ph]);
      set_high_water(hw);
      steady = (ph == 3);          // one phase without any idling
      ev_cut = EVENT_PCT[ph];
      rd_cut = ev_cut + READ_PCT[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        case (rd_mode)
          MODE_CLOSED: op = (r < 85) ? OP_OPEN : op_t'($urandom_range(3));
          MODE_EOF:    op = (r < 60) ? OP_READ : (r < 90) ? OP_CLOSE
                                               : op_t'($urandom_range(3));
          default:     op = (r < ev_cut) ? OP_EVENT : (r < rd_cut) ? OP_READ
                          : (r < rd_cut + 2) ? OP_OPEN : OP_CLOSE;
        endcase
        w   = ($urandom_range(99) < 10);
        e   = ($urandom_range(99) < ERROR_PCT[ph]);
        d   = (op == OP_READ) ? 1'($urandom_range(1)) : ($urandom_range(99) < 8);
        col = 8'($urandom_range(255));
        // events while closed or at end of file are no-ops for the block
        if (!(op == OP_EVENT && (rd_mode == MODE_CLOSED || rd_mode == MODE_EOF)))
          sent++;
        send_request(op, w, e, d, col, 1'b0, NO_WANT);
        if (ph == 2 && sent == PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          wait_drained();          // sender holds off until all results are back
        end
      end
    end

    in_tvalid <= 1'b0;
    steady = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("card_reader_column_queue_unit: match");
    end else begin
      $display("card_reader_column_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> card_reader_column_queue_unit.f
+incdir+hdl
hdl/crcq_pkg.sv
hdl/crcq_ctrl.sv
hdl/crcq_dp.sv
hdl/card_reader_column_queue_unit.sv
tb/tb.sv
